// ----- hw/rtl/vrpa_pkg.sv -----
// ----------------------------------------------------------------------------
// vrpa_pkg
// Shared types and constants for the protected pixel access unit.
// ----------------------------------------------------------------------------
package vrpa_pkg;

  typedef enum logic [2:0] {
    OP_VRAM_WR = 3'd0,
    OP_BM_RD   = 3'd1,
    OP_BM_WR   = 3'd2,
    OP_LATCH_WR = 3'd3,
    OP_CTL_WR  = 3'd4,
    OP_TBL_LD  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  localparam int unsigned VRAM_ROWS  = 16384;
  localparam int unsigned OFF_W      = $clog2(VRAM_ROWS);
  localparam int unsigned TBL_DEPTH  = 256;
  localparam int unsigned TBL_IDX_W  = $clog2(TBL_DEPTH);
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // one classified access, handed from front to back
  typedef struct packed {
    kind_e              kind;
    logic [OFF_W-1:0]   off;
    logic [7:0]         data;
    logic [1:0]         sel;   // x latch bits 1:0 for bit-mode reads
    logic [3:0]         wp;    // write-protect mask from the table
  } acc_t;

endpackage

// ----- hw/rtl/vrpa_front.sv -----
// ----------------------------------------------------------------------------
// vrpa_front
// Accepts accesses, owns latches, control bits and the protect table, and
// turns each access into a classified entry, writes with their protect mask.
// ----------------------------------------------------------------------------
module vrpa_front
  import vrpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        full_i,
  output logic        push_o,
  output acc_t        entry_o
);

  logic [7:0]           x_q, y_q;
  logic [7:0]           ctl_q;
  logic                 f_valid_q;
  kind_e                f_kind_q;
  logic [OFF_W-1:0]     f_off_q;
  logic [7:0]           f_data_q;
  logic [1:0]           f_sel_q;
  logic [3:0]           tbl_mem [TBL_DEPTH];
  logic [3:0]           tbl_rdata_q;

  logic                 accept;
  kind_e                kind;
  logic [15:0]          wa;
  logic [OFF_W-1:0]     off;
  logic [7:0]           data;
  logic                 bmode;
  logic [1:0]           pix;
  logic [OFF_W-1:0]     bm_off;
  logic [TBL_IDX_W-1:0] idx;

  assign push_o     = f_valid_q & ~full_i;
  assign in_ready_o = ~f_valid_q | push_o;
  assign accept     = in_valid_i & in_ready_o;
  assign bm_off     = {y_q, x_q[7:2]};

  always_comb begin
    kind  = KIND_NONE;
    wa    = address_i;
    off   = address_i[OFF_W-1:0];
    data  = write_data_i;
    bmode = 1'b0;
    pix   = 2'b00;
    case (op_e'(opcode_i))
      OP_VRAM_WR, OP_LATCH_WR: begin
        kind = KIND_WRITE;
      end
      OP_BM_RD: begin
        kind = KIND_READ;
        off  = bm_off;
        pix  = x_q[1:0];
      end
      OP_BM_WR: begin
        kind  = KIND_WRITE;
        wa    = {{(16-OFF_W){1'b0}}, bm_off};
        off   = bm_off;
        data  = {write_data_i[3:0], write_data_i[3:0]};
        bmode = 1'b1;
        pix   = x_q[1:0];
      end
      default: begin
        kind = KIND_NONE;
      end
    endcase
    idx = {bmode, ctl_q[4], ctl_q[6], wa[15:12] != 4'h4, wa[13:11] == 3'b000,
           wa[10:9] == 2'b11, pix};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      ctl_q     <= '0;
      f_valid_q <= 1'b0;
      f_kind_q  <= KIND_NONE;
    end else begin
      if (accept) begin
        f_valid_q <= 1'b1;
        f_kind_q  <= kind;
        case (op_e'(opcode_i))
          OP_BM_RD, OP_BM_WR: begin
            if (!ctl_q[0]) x_q <= x_q + 8'd1;
            if (!ctl_q[1]) y_q <= y_q + 8'd1;
          end
          OP_LATCH_WR: begin
            if (address_i[0]) y_q <= write_data_i;
            else              x_q <= write_data_i;
          end
          OP_CTL_WR: begin
            ctl_q[address_i[2:0]] <= write_data_i[7];
          end
          default: begin
          end
        endcase
      end else if (push_o) begin
        f_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_off_q  <= off;
      f_data_q <= data;
      f_sel_q  <= pix;
    end
  end

  // protect table: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (accept && op_e'(opcode_i) == OP_TBL_LD) begin
      tbl_mem[address_i[TBL_IDX_W-1:0]] <= write_data_i[3:0];
    end
    if (accept && kind == KIND_WRITE) begin
      tbl_rdata_q <= tbl_mem[idx];
    end
  end

  assign entry_o = '{kind: f_kind_q, off: f_off_q, data: f_data_q,
                     sel: f_sel_q, wp: tbl_rdata_q};

endmodule

// ----- hw/rtl/vrpa_queue.sv -----
// ----------------------------------------------------------------------------
// vrpa_queue
// Short FIFO of classified accesses between front and back.
// ----------------------------------------------------------------------------
module vrpa_queue
  import vrpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  acc_t entry_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output acc_t entry_o
);

  acc_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

// ----- hw/rtl/vrpa_back.sv -----
// ----------------------------------------------------------------------------
// vrpa_back
// Executes queued accesses on the two-bank video memory and drives results.
// ----------------------------------------------------------------------------
module vrpa_back
  import vrpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  acc_t       entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o
);

  // one row holds bank 1 in [15:8] and bank 0 in [7:0] at the same offset
  logic [15:0] vram_mem [VRAM_ROWS];
  logic [15:0] rd_row_q;
  logic [1:0]  rd_sel_q;
  logic        rd_pend_q;
  logic        out_valid_q;
  logic [7:0]  read_data_q;

  logic [3:0]  nib_en;
  logic [15:0] wdata;
  logic [7:0]  rd_byte;
  logic [3:0]  rd_nib;

  assign pop_o  = q_valid_i & ~rd_pend_q & (~out_valid_q | out_ready_i);
  assign nib_en = ~{entry_i.wp[0], entry_i.wp[1], entry_i.wp[2], entry_i.wp[3]};
  assign wdata  = {entry_i.data, entry_i.data};

  // x bit 1 clear selects bank 1; x bit 0 clear selects the high nibble
  assign rd_byte = rd_sel_q[1] ? rd_row_q[7:0] : rd_row_q[15:8];
  assign rd_nib  = rd_sel_q[0] ? rd_byte[3:0] : rd_byte[7:4];

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.kind == KIND_WRITE) begin
      for (int i = 0; i < 4; i++) begin
        if (nib_en[i]) vram_mem[entry_i.off][i*4 +: 4] <= wdata[i*4 +: 4];
      end
    end
    if (pop_o && entry_i.kind == KIND_READ) begin
      rd_row_q <= vram_mem[entry_i.off];
      rd_sel_q <= entry_i.sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      if (rd_pend_q) begin
        // output slot was freed when the read was issued
        rd_pend_q   <= 1'b0;
        out_valid_q <= 1'b1;
        read_data_q <= {4'hf, rd_nib};
      end else if (pop_o) begin
        if (entry_i.kind == KIND_READ) begin
          rd_pend_q   <= 1'b1;
          out_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b1;
          read_data_q <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

`ifndef SYNTH
  a_pend_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("read pending while output slot busy");

  a_pend_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q && read_data_q[7:4] == 4'hf)
    else $error("bit-mode read result missing or malformed");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i && !rd_pend_q)
    else $error("pop without a queued beat");

  a_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && read_data_q[7:4] != 4'hf) |-> read_data_q == 8'h00)
    else $error("non-read result not zero");
`endif

endmodule

// ----- hw/rtl/video_ram_protected_pixel_access_unit.sv -----
// ----------------------------------------------------------------------------
// video_ram_protected_pixel_access_unit
// Protected bus-access engine for a two-bank nibble-pixel video memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one access per beat:
//   opcode_i, address_i, write_data_i. Output channel
//   (out_valid_o/out_ready_i) returns one read_data_o beat per access, in
//   order; it is zero except for bit-mode reads (upper nibble ones).
//   The front registers the access and reads the protect table in the same
//   cycle, then hands it through a two-entry queue to the back, which owns
//   the single video memory port. Writes update both banks in one port
//   access with nibble enables; bit-mode reads register the row from the
//   port and then the selected pixel as the result.
//   A write or control access passes the front register, a queue entry and
//   the output register; a bit-mode read also passes the row register, and
//   the back takes no new access from the queue while that read is pending.
//   Reset clears latches, control bits, queue and output; video memory and
//   protect table are not cleared and must be written before use.
//   When the receiver stalls, the result holds, the back stops, the queue
//   fills and then in_ready_o drops.
// ----------------------------------------------------------------------------
module video_ram_protected_pixel_access_unit
  import vrpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o
);

  logic push, full, pop, q_valid;
  acc_t f_entry, q_entry;

  vrpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (f_entry)
  );

  vrpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  vrpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .entry_i     (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o)
  );

endmodule

// ----- sim/video_ram_protected_pixel_access_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_ram_protected_pixel_access_unit_tb
// Self-checking bench for the protected pixel access unit. It loads the
// protect table and fills the lower rows of both video banks, then runs
// directed accesses and random traffic under several sender and receiver
// idling patterns. A behavioral copy of the unit predicts every read_data
// beat, and the bench checks each one in order.
// ----------------------------------------------------------------------------
module video_ram_protected_pixel_access_unit_tb;
  import vrpa_pkg::*;

  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
  } read_expect_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i     = '0;
  logic [15:0] address_i    = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  read_data_o;

  // behavioral copy of the unit's state
  logic [7:0] vram_model [0:32767];
  logic [1:0] vram_known [0:32767];   // per-nibble written marks, [1] is high
  logic [3:0] wp_table   [0:255];
  logic       ctl_bits   [0:7];
  logic [7:0] x_pos = '0;
  logic [7:0] y_pos = '0;

  read_expect_t pending_reads [$];
  read_expect_t head;
  int fail_count     = 0;
  int idle_cycles    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  video_ram_protected_pixel_access_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < 8; i++) ctl_bits[i] = 1'b0;
    for (int i = 0; i < 32768; i++) vram_known[i] = 2'b00;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic void guarded_store(input logic [15:0] a, input logic [7:0] d,
                                        input logic bm, input logic [1:0] pix);
    logic [7:0]  idx;
    logic [3:0]  wp;
    logic [13:0] o;
    o   = a[13:0];
    idx = {bm, ctl_bits[4], ctl_bits[6], a[15:12] != 4'h4, a[13:11] == 3'b000,
           a[10:9] == 2'b11, pix};
    wp  = wp_table[idx];
    if (!wp[0]) begin
      vram_model[{1'b1, o}][7:4] = d[7:4];
      vram_known[{1'b1, o}][1]   = 1'b1;
    end
    if (!wp[1]) begin
      vram_model[{1'b1, o}][3:0] = d[3:0];
      vram_known[{1'b1, o}][0]   = 1'b1;
    end
    if (!wp[2]) begin
      vram_model[{1'b0, o}][7:4] = d[7:4];
      vram_known[{1'b0, o}][1]   = 1'b1;
    end
    if (!wp[3]) begin
      vram_model[{1'b0, o}][3:0] = d[3:0];
      vram_known[{1'b0, o}][0]   = 1'b1;
    end
  endfunction

  function automatic void step_latches();
    if (!ctl_bits[0]) x_pos = x_pos + 8'd1;
    if (!ctl_bits[1]) y_pos = y_pos + 8'd1;
  endfunction

  function automatic logic [7:0] apply_access(input logic [2:0] op, input logic [15:0] a,
                                              input logic [7:0] d);
    logic [15:0] bm_addr;
    logic [7:0]  pix_byte;
    logic [7:0]  result;
    result  = 8'h00;
    bm_addr = {2'b00, y_pos, x_pos[7:2]};
    case (op)
      OP_VRAM_WR: guarded_store(a, d, 1'b0, 2'b00);
      OP_BM_RD: begin
        // x bit 1 clear selects bank 1
        pix_byte = vram_model[{~x_pos[1], bm_addr[13:0]}];
        result   = {4'hf, x_pos[0] ? pix_byte[3:0] : pix_byte[7:4]};
        step_latches();
      end
      OP_BM_WR: begin
        guarded_store(bm_addr, {d[3:0], d[3:0]}, 1'b1, x_pos[1:0]);
        step_latches();
      end
      OP_LATCH_WR: begin
        guarded_store(a, d, 1'b0, 2'b00);
        if (a[0]) y_pos = d;
        else x_pos = d;
      end
      OP_CTL_WR: ctl_bits[a[2:0]] = d[7];
      OP_TBL_LD: wp_table[a[7:0]] = d[3:0];
      default: ;
    endcase
    return result;
  endfunction

  // --------------------------------------------------------------------------
  // driving and checking
  // --------------------------------------------------------------------------
  task automatic send_access(input logic [2:0] op, input logic [15:0] a, input logic [7:0] d);
    read_expect_t e;
    logic [14:0]  rd_loc;
    // a bit-mode read of a pixel never written goes out as a bit-mode write;
    // both step the latches the same way
    rd_loc = {~x_pos[1], y_pos, x_pos[7:2]};
    if (op == OP_BM_RD && !vram_known[rd_loc][~x_pos[0]]) op = OP_BM_WR;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= a;
    write_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    e.op   = op;
    e.addr = a;
    e.data = apply_access(op, a, d);
    pending_reads.push_back(e);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reads.size() == 0) begin
        note_failure($sformatf("unexpected beat: read_data %h", read_data_o));
      end else begin
        head = pending_reads.pop_front();
        if (read_data_o !== head.data)
          note_failure($sformatf("read_data mismatch: op %0d addr %h exp %h got %h",
                                 head.op, head.addr, head.data, read_data_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // table and video memory come up undefined: open the table, fill the rows
  // that bit-mode runs start in
  task automatic test_store_init();
    for (int i = 0; i < 256; i++)
      send_access(OP_TBL_LD, 16'(i), {4'($urandom_range(15)), 4'h0});
    for (int i = 0; i < 256; i++)
      send_access(OP_VRAM_WR, {2'($urandom_range(3)), 14'(i)}, 8'($urandom_range(255)));
  endtask

  task automatic test_directed_access();
    send_access(OP_TBL_LD, 16'hff05, 8'hfa);       // wide table index
    send_access(OP_VRAM_WR, 16'h0000, 8'hff);
    send_access(OP_VRAM_WR, 16'hffff, 8'h00);
    send_access(OP_VRAM_WR, 16'h4000, 8'h5a);
    send_access(OP_VRAM_WR, 16'h0600, 8'ha5);
    send_access(OP_LATCH_WR, 16'hfffe, 8'hff);     // x at top, wraps below
    send_access(OP_LATCH_WR, 16'h0001, 8'h00);
    repeat (4) send_access(OP_BM_RD, 16'hffff, 8'hff);
    send_access(OP_BM_WR, 16'h0000, 8'hff);
    send_access(OP_BM_WR, 16'hffff, 8'h00);
    send_access(OP_LATCH_WR, 16'h0000, 8'h01);
    send_access(OP_BM_RD, 16'h0000, 8'h00);
    send_access(OP_BM_RD, 16'h0000, 8'h00);
    send_access(OP_CTL_WR, 16'hfff8, 8'h80);       // x hold, wide index
    send_access(OP_CTL_WR, 16'h0001, 8'hff);       // y hold
    send_access(OP_BM_RD, 16'h0000, 8'h00);
    send_access(OP_CTL_WR, 16'h0004, 8'h80);
    send_access(OP_CTL_WR, 16'h0006, 8'h80);
    send_access(OP_VRAM_WR, 16'h1234, 8'h3c);
    send_access(OP_UNUSED6, 16'hffff, 8'hff);
    send_access(OP_UNUSED7, 16'h0000, 8'h00);
    for (int i = 0; i < 8; i++) send_access(OP_CTL_WR, 16'(i), 8'h7f);
  endtask

  function automatic logic [2:0] pick_opcode();
    int r;
    r = $urandom_range(99);
    if (r < 20) return OP_VRAM_WR;
    if (r < 45) return OP_BM_RD;
    if (r < 65) return OP_BM_WR;
    if (r < 75) return OP_LATCH_WR;
    if (r < 85) return OP_CTL_WR;
    if (r < 95) return OP_TBL_LD;
    return $urandom_range(1) ? OP_UNUSED7 : OP_UNUSED6;
  endfunction

  task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
    int         sent;
    int         burst;
    logic [2:0] op;
    logic [7:0] d;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 20) begin
        // position the latches near the filled rows, then a run of pixels
        send_access(OP_LATCH_WR, 16'($urandom_range(65535)) & 16'hfffe, 8'($urandom_range(255)));
        send_access(OP_LATCH_WR, 16'($urandom_range(65535)) | 16'h0001, 8'($urandom_range(3)));
        burst = $urandom_range(3, 8);
        repeat (burst)
          send_access(($urandom_range(99) < 60) ? OP_BM_RD : OP_BM_WR,
                      16'($urandom_range(65535)), 8'($urandom_range(255)));
        sent += burst + 2;
      end else begin
        op = pick_opcode();
        d  = 8'($urandom_range(255));
        // keep about half the table entries open so writes land
        if (op == OP_TBL_LD && $urandom_range(1)) d = d & 8'hf0;
        send_access(op, 16'($urandom_range(65535)), d);
        sent++;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_store_init();
    test_directed_access();
    test_random_traffic(220, 0, 0);
    test_random_traffic(220, 46, 0);
    test_random_traffic(220, 0, 46);
    test_random_traffic(220, 9, 9);
    drain_results();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
